// ===== design/jmt_pkg.sv =====
// shared types and constants for the jerk-minimizing trajectory coefficient unit
// no dependencies; used by jmt_front, jmt_div and the top level
package jmt_pkg;

  localparam int VAL_W = 32;
  localparam int DUR_W = 24;
  localparam int NUM_W = 88;
  localparam int MAG_W = NUM_W - 1;
  localparam int DEN_W = 121;
  localparam int RW    = 156;
  localparam int QB    = 33;
  localparam int DIV_LAT = QB + 2;
  localparam int LANES = 3;

  localparam int LANE_SHIFT [LANES] = '{15, 31, 47};
  localparam logic signed [7:0] DP_GAIN [LANES] = '{8'sd20, -8'sd30, 8'sd12};

  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic signed [VAL_W-1:0] coef0;
    logic signed [VAL_W-1:0] coef1;
    logic signed [VAL_W-1:0] coef2;
  } side_t;

  typedef struct packed {
    logic [RW-1:0]    x;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_in_t;

endpackage

// ===== design/jmt_in_if.sv =====
// input channel: start and end states plus duration, valid/ready handshake
// no dependencies
interface jmt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_pos;
  logic signed [31:0] start_vel;
  logic signed [31:0] start_acc;
  logic signed [31:0] end_pos;
  logic signed [31:0] end_vel;
  logic signed [31:0] end_acc;
  logic [23:0]        duration;

  modport source (output valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
                  duration, input ready);
  modport sink (input valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
                duration, output ready);
endinterface

// ===== design/jmt_out_if.sv =====
// output channel: six polynomial coefficients and two flags, valid/ready handshake
// no dependencies
interface jmt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef0;
  logic signed [31:0] coef1;
  logic signed [31:0] coef2;
  logic signed [31:0] coef3;
  logic signed [31:0] coef4;
  logic signed [31:0] coef5;
  logic               zero_duration;
  logic               clipped;

  modport source (output valid, coef0, coef1, coef2, coef3, coef4, coef5, zero_duration,
                  clipped, input ready);
  modport sink (input valid, coef0, coef1, coef2, coef3, coef4, coef5, zero_duration,
                clipped, output ready);
endinterface

// ===== design/jmt_front.sv =====
// six-stage front end: powers of the duration and the three numerators
// depends on jmt_pkg and jmt_in_if
module jmt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  jmt_in_if.sink                req,
  output jmt_pkg::side_t        side,
  output jmt_pkg::div_in_t      lane [jmt_pkg::LANES]
);
  import jmt_pkg::*;

  // stage a: input capture
  logic                    a_vld;
  logic signed [VAL_W-1:0] a_ps, a_vs, a_as, a_pe, a_ve, a_ae;
  logic [DUR_W-1:0]        a_d;

  // stage b: combos and d squared
  side_t                   b_side;
  logic signed [32:0]      b_dp;
  logic signed [37:0]      b_vc [LANES];
  logic signed [35:0]      b_ac [LANES];
  logic [DUR_W-1:0]        b_d;
  logic [2*DUR_W-1:0]      b_dd;

  // stage c: partial products
  side_t                   c_side;
  logic signed [32:0]      c_dp;
  logic signed [62:0]      c_pv [LANES];
  logic signed [60:0]      c_plo [LANES];
  logic signed [60:0]      c_phi [LANES];
  logic [DUR_W-1:0]        c_d;
  logic [47:0]             c_d3lo, c_d3hi, c_d4hh, c_d4hl, c_d4ll;

  // stage d: numerators, d^3, d^4
  side_t                   d_side;
  logic signed [NUM_W-1:0] d_n [LANES];
  logic [71:0]             d_d3;
  logic [95:0]             d_d4;
  logic [DUR_W-1:0]        d_d;

  // stage e: sign and magnitude, d^5 partials
  side_t                   e_side;
  logic                    e_neg [LANES];
  logic [MAG_W-1:0]        e_mag [LANES];
  logic [71:0]             e_d3;
  logic [95:0]             e_d4;
  logic [47:0]             e_p5 [4];

  // combinational logic for stage b, the stage d numerators and the d^5 sum
  logic signed [37:0]      ve_x, vs_x;
  logic signed [35:0]      ae_x, as_x;
  logic signed [32:0]      half_acc;
  logic signed [VAL_W:0]   acc_rnd;
  logic                    dur_zero;
  logic signed [NUM_W-1:0] n_sum [LANES];
  logic [119:0]            d5_sum;
  logic signed [37:0]      b_vc_comb_0, b_vc_comb_1, b_vc_comb_2;
  logic signed [35:0]      b_ac_comb_0, b_ac_comb_1, b_ac_comb_2;

  always_comb begin
    ve_x = 38'(a_ve);
    vs_x = 38'(a_vs);
    ae_x = 36'(a_ae);
    as_x = 36'(a_as);
    b_vc_comb_0 = -(ve_x * 38'sd8 + vs_x * 38'sd12);
    b_vc_comb_1 = ve_x * 38'sd14 + vs_x * 38'sd16;
    b_vc_comb_2 = -((ve_x + vs_x) * 38'sd6);
    b_ac_comb_0 = ae_x - as_x * 36'sd3;
    b_ac_comb_1 = as_x * 36'sd3 - ae_x * 36'sd2;
    b_ac_comb_2 = ae_x - as_x;
    acc_rnd  = 33'(a_as) + (a_as[VAL_W-1] ? 33'sd0 : 33'sd1);
    half_acc = acc_rnd >>> 1;
    dur_zero = (a_d == '0);
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      n_sum[k] = ((NUM_W'(c_dp) * NUM_W'(DP_GAIN[k])) <<< 32)
               + (NUM_W'(c_pv[k]) <<< 16)
               + (NUM_W'(c_phi[k]) <<< 24)
               + NUM_W'(c_plo[k]);
    end
    d5_sum = (120'(e_p5[3]) << 72) + (120'(e_p5[2]) << 48)
           + (120'(e_p5[1]) << 24) + 120'(e_p5[0]);
  end

  always_ff @(posedge clk) begin
    // valid bits
    if (rst) begin
      a_vld      <= 1'b0;
      b_side.vld <= 1'b0;
      c_side.vld <= 1'b0;
      d_side.vld <= 1'b0;
      e_side.vld <= 1'b0;
      side.vld   <= 1'b0;
    end else if (en) begin
      a_vld      <= req.valid;
      b_side.vld <= a_vld;
      c_side.vld <= b_side.vld;
      d_side.vld <= c_side.vld;
      e_side.vld <= d_side.vld;
      side.vld   <= e_side.vld;
    end

    // datapath
    if (en) begin
      a_ps <= req.start_pos;
      a_vs <= req.start_vel;
      a_as <= req.start_acc;
      a_pe <= req.end_pos;
      a_ve <= req.end_vel;
      a_ae <= req.end_acc;
      a_d  <= req.duration;

      b_side.zero  <= dur_zero;
      b_side.coef0 <= dur_zero ? '0 : a_ps;
      b_side.coef1 <= dur_zero ? '0 : a_vs;
      b_side.coef2 <= dur_zero ? '0 : half_acc[VAL_W-1:0];
      b_dp     <= 33'(a_pe) - 33'(a_ps);
      b_vc[0]  <= b_vc_comb_0;
      b_vc[1]  <= b_vc_comb_1;
      b_vc[2]  <= b_vc_comb_2;
      b_ac[0]  <= b_ac_comb_0;
      b_ac[1]  <= b_ac_comb_1;
      b_ac[2]  <= b_ac_comb_2;
      b_d      <= a_d;
      b_dd     <= a_d * a_d;

      c_side.zero  <= b_side.zero;
      c_side.coef0 <= b_side.coef0;
      c_side.coef1 <= b_side.coef1;
      c_side.coef2 <= b_side.coef2;
      c_dp <= b_dp;
      c_d  <= b_d;
      for (int k = 0; k < LANES; k++) begin
        c_pv[k]  <= b_vc[k] * $signed({1'b0, b_d});
        c_plo[k] <= b_ac[k] * $signed({1'b0, b_dd[23:0]});
        c_phi[k] <= b_ac[k] * $signed({1'b0, b_dd[47:24]});
      end
      c_d3lo <= b_dd[23:0] * b_d;
      c_d3hi <= b_dd[47:24] * b_d;
      c_d4hh <= b_dd[47:24] * b_dd[47:24];
      c_d4hl <= b_dd[47:24] * b_dd[23:0];
      c_d4ll <= b_dd[23:0] * b_dd[23:0];

      d_side.zero  <= c_side.zero;
      d_side.coef0 <= c_side.coef0;
      d_side.coef1 <= c_side.coef1;
      d_side.coef2 <= c_side.coef2;
      for (int k = 0; k < LANES; k++) begin
        d_n[k] <= n_sum[k];
      end
      d_d3 <= (72'(c_d3hi) << 24) + 72'(c_d3lo);
      d_d4 <= (96'(c_d4hh) << 48) + (96'(c_d4hl) << 25) + 96'(c_d4ll);
      d_d  <= c_d;

      e_side.zero  <= d_side.zero;
      e_side.coef0 <= d_side.coef0;
      e_side.coef1 <= d_side.coef1;
      e_side.coef2 <= d_side.coef2;
      for (int k = 0; k < LANES; k++) begin
        e_neg[k] <= d_n[k][NUM_W-1];
        e_mag[k] <= d_n[k][NUM_W-1] ? MAG_W'(-d_n[k]) : MAG_W'(d_n[k]);
      end
      for (int j = 0; j < 4; j++) begin
        e_p5[j] <= d_d4[24*j +: 24] * d_d;
      end
      e_d3 <= d_d3;
      e_d4 <= d_d4;

      side.zero  <= e_side.zero;
      side.coef0 <= e_side.coef0;
      side.coef1 <= e_side.coef1;
      side.coef2 <= e_side.coef2;
      for (int k = 0; k < LANES; k++) begin
        lane[k].x   <= RW'(e_mag[k]) << LANE_SHIFT[k];
        lane[k].neg <= e_neg[k];
      end
      lane[0].den <= DEN_W'(e_d3);
      lane[1].den <= DEN_W'(e_d4);
      lane[2].den <= DEN_W'(d5_sum);
    end
  end

endmodule

// ===== design/jmt_div.sv =====
// pipelined restoring divider lane: one quotient bit per stage, then round and saturate
// depends on jmt_pkg
module jmt_div (
  input  logic                 clk,
  input  logic                 en,
  input  jmt_pkg::div_in_t     din,
  output logic signed [31:0]   coef,
  output logic                 clip
);
  import jmt_pkg::*;

  logic [RW-1:0]    r   [QB+1];
  logic [QB-1:0]    q   [QB+1];
  logic             big [QB+1];
  logic             neg [QB+1];
  logic [DEN_W-1:0] den [QB+1];

  // overflow check against den * 2^QB
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= din.x;
      big[0] <= din.x >= (RW'(din.den) << QB);
      q[0]   <= '0;
      neg[0] <= din.neg;
      den[0] <= din.den;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    localparam int BIT = QB - s;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(den[s-1]) << BIT;
    assign ge  = r[s-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        r[s]   <= ge ? r[s-1] - dsh : r[s-1];
        q[s]   <= q[s-1] | ({{(QB-1){1'b0}}, ge} << BIT);
        big[s] <= big[s-1];
        neg[s] <= neg[s-1];
        den[s] <= den[s-1];
      end
    end
  end

  // round half away from zero, then clamp
  logic          rnd;
  logic [QB:0]   qr, limit, qs;
  logic          over;

  always_comb begin
    rnd   = (r[QB] << 1) >= RW'(den[QB]);
    qr    = {1'b0, q[QB]} + (QB+1)'(rnd);
    limit = neg[QB] ? (QB+1)'(34'h80000000) : (QB+1)'(34'h7FFFFFFF);
    over  = big[QB] || (qr > limit);
    qs    = over ? limit : qr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef <= neg[QB] ? -$signed(qs[31:0]) : $signed(qs[31:0]);
      clip <= over;
    end
  end

endmodule

// ===== design/jerk_min_trajectory_coeffs_unit.sv =====
// top level: minimum-jerk quintic coefficients, front end plus three divider lanes
// depends on jmt_pkg, jmt_in_if, jmt_out_if, jmt_front, jmt_div
//
//   channel  kind  direction  content
//   req      in    sink       start/end position, velocity, acceleration, duration
//   rsp      out   source     coef0..coef5, zero_duration, clipped
//
// one item per cycle unless rsp stalls; the path from req to rsp runs through
// 6 front-end stages, 33 divider bit stages, and the check and round stages
// the latency is set by the one-bit-per-stage dividers for coef3..coef5
// rst clears only the valid bits; data registers are not reset
// the whole pipeline holds while rsp is valid and not taken, req.ready low
module jerk_min_trajectory_coeffs_unit (
  input logic     clk,
  input logic     rst,
  jmt_in_if.sink  req,
  jmt_out_if.source rsp
);
  import jmt_pkg::*;

  logic           en;
  side_t          side_f;
  div_in_t        lane [LANES];
  side_t          side_d [DIV_LAT];
  logic signed [VAL_W-1:0] coef_q [LANES];
  logic           clip_q [LANES];

  assign en        = !side_d[DIV_LAT-1].vld || rsp.ready;
  assign req.ready = en;

  jmt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .req  (req),
    .side (side_f),
    .lane (lane)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    jmt_div u_div (
      .clk  (clk),
      .en   (en),
      .din  (lane[k]),
      .coef (coef_q[k]),
      .clip (clip_q[k])
    );
  end

  // sideband delay matching the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        side_d[i].vld <= 1'b0;
      end
    end else if (en) begin
      side_d[0].vld <= side_f.vld;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_d[i].vld <= side_d[i-1].vld;
      end
    end

    if (en) begin
      side_d[0].zero  <= side_f.zero;
      side_d[0].coef0 <= side_f.coef0;
      side_d[0].coef1 <= side_f.coef1;
      side_d[0].coef2 <= side_f.coef2;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_d[i].zero  <= side_d[i-1].zero;
        side_d[i].coef0 <= side_d[i-1].coef0;
        side_d[i].coef1 <= side_d[i-1].coef1;
        side_d[i].coef2 <= side_d[i-1].coef2;
      end
    end
  end

  assign rsp.valid         = side_d[DIV_LAT-1].vld;
  assign rsp.coef0         = side_d[DIV_LAT-1].coef0;
  assign rsp.coef1         = side_d[DIV_LAT-1].coef1;
  assign rsp.coef2         = side_d[DIV_LAT-1].coef2;
  assign rsp.coef3         = side_d[DIV_LAT-1].zero ? '0 : coef_q[0];
  assign rsp.coef4         = side_d[DIV_LAT-1].zero ? '0 : coef_q[1];
  assign rsp.coef5         = side_d[DIV_LAT-1].zero ? '0 : coef_q[2];
  assign rsp.zero_duration = side_d[DIV_LAT-1].zero;
  assign rsp.clipped       = !side_d[DIV_LAT-1].zero && (clip_q[0] || clip_q[1] || clip_q[2]);

endmodule

// ===== tb/tb_jmt_channels.sv =====
// testbench view of the request and response channels
// the channel interfaces themselves come from the design files jmt_in_if and jmt_out_if
`timescale 1ns / 1ps
package tb_jmt_types;
  typedef struct {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
    logic [23:0]        duration;
  } traj_req_t;

  typedef struct {
    logic [31:0] coef [6];
    logic        zero_duration;
    logic        clipped;
  } traj_coef_t;
endpackage

// ===== tb/tb_jerk_min_trajectory_coeffs_unit.sv =====
// testbench for jerk_min_trajectory_coeffs_unit: random and directed trajectory requests
// depends on jmt_pkg, jmt_in_if, jmt_out_if and tb_jmt_types; checks every coefficient
`timescale 1ns / 1ps
module tb_jerk_min_trajectory_coeffs_unit;
  import tb_jmt_types::*;

  class coef_scoreboard;
    traj_coef_t pending[$];
    int errors;
    int shown;

    // round(num * 2^sh / den), ties away from zero, saturated to 32 bits
    function logic [31:0] sat_quot(logic signed [127:0] num, logic [127:0] den, int sh,
                                   ref logic clip);
      logic [127:0] mag;
      logic [255:0] q;
      logic [255:0] r;
      logic [255:0] lim;
      logic neg;
      neg = num[127];
      mag = neg ? -num : num;
      q = ({128'd0, mag} << sh) / {128'd0, den};
      r = ({128'd0, mag} << sh) % {128'd0, den};
      if ((r << 1) >= {128'd0, den}) q = q + 1;
      lim = neg ? 256'h80000000 : 256'h7FFFFFFF;
      if (q > lim) begin
        clip = 1'b1;
        q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_request(traj_req_t t);
      traj_coef_t e;
      logic signed [63:0] dp, a0, ve, vs, ae, as_;
      logic [63:0] d, m;
      logic [127:0] dd, sd, d3, d4, d5;
      logic signed [127:0] n3, n4, n5;
      logic clip;
      clip = 0;
      for (int i = 0; i < 6; i++) e.coef[i] = '0;
      e.zero_duration = 0;
      e.clipped = 0;
      if (t.duration == 0) begin
        e.zero_duration = 1;
      end else begin
        e.coef[0] = t.start_pos;
        e.coef[1] = t.start_vel;
        as_ = t.start_acc;
        m = as_ < 0 ? -as_ : as_;
        m = (m + 1) >> 1;
        e.coef[2] = as_ < 0 ? -m[31:0] : m[31:0];
        a0 = t.start_pos;
        dp = t.end_pos - a0;
        ve = t.end_vel;
        vs = t.start_vel;
        ae = t.end_acc;
        d = t.duration;
        dd = d * d;
        sd = d << 16;
        d3 = dd * d;
        d4 = dd * dd;
        d5 = d4 * d;
        n3 = ((128'(20 * dp)) <<< 32) + 128'(-(8 * ve + 12 * vs)) * $signed(sd)
             + 128'(ae - 3 * as_) * $signed(dd);
        n4 = ((128'(-30 * dp)) <<< 32) + 128'(14 * ve + 16 * vs) * $signed(sd)
             + 128'(3 * as_ - 2 * ae) * $signed(dd);
        n5 = ((128'(12 * dp)) <<< 32) + 128'(-6 * (ve + vs)) * $signed(sd)
             + 128'(ae - as_) * $signed(dd);
        e.coef[3] = sat_quot(n3, d3, 15, clip);
        e.coef[4] = sat_quot(n4, d4, 31, clip);
        e.coef[5] = sat_quot(n5, d5, 47, clip);
        e.clipped = clip;
      end
      pending = {pending, e};
    endfunction

    function void check_result(traj_coef_t got);
      traj_coef_t e;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result coef3=%h", got.coef[3]);
        end
        return;
      end
      e = pending.pop_front();
      bad = (got.zero_duration !== e.zero_duration) || (got.clipped !== e.clipped);
      for (int i = 0; i < 6; i++) if (got.coef[i] !== e.coef[i]) bad = 1;
      if (bad) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch exp %h %h %h %h %h %h z%b c%b got %h %h %h %h %h %h z%b c%b",
                   e.coef[0], e.coef[1], e.coef[2], e.coef[3], e.coef[4], e.coef[5],
                   e.zero_duration, e.clipped, got.coef[0], got.coef[1], got.coef[2],
                   got.coef[3], got.coef[4], got.coef[5], got.zero_duration, got.clipped);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  jmt_in_if req();
  jmt_out_if rsp();
  coef_scoreboard board = new();
  int hold_cycles = 0;
  bit calm = 0;
  bit sending_done = 0;

  jerk_min_trajectory_coeffs_unit DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #5 clk = ~clk;

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3FFFF) : -$urandom_range(0, 32'h3FFFF);
      3: return $urandom_range(0, 1) ? $urandom_range(0, 32'hFFFFFF) : -$urandom_range(0, 32'hFFFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_dur();
    case ($urandom_range(0, 7))
      0: return 24'hFFFFFF;
      1: return 24'($urandom_range(1, 16));
      2: return 0;
      3: return 24'($urandom_range(24'h8000, 24'h40000));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_request(traj_req_t t);
    req.valid <= 1;
    req.start_pos <= t.start_pos;
    req.start_vel <= t.start_vel;
    req.start_acc <= t.start_acc;
    req.end_pos <= t.end_pos;
    req.end_vel <= t.end_vel;
    req.end_acc <= t.end_acc;
    req.duration <= t.duration;
    do @(posedge clk); while (!req.ready);
    board.note_request(t);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 23) begin
      req.valid <= 0;
      @(negedge clk);
    end
  endtask

  function automatic traj_req_t random_request();
    traj_req_t t;
    t.start_pos = pick_val();
    t.start_vel = pick_val();
    t.start_acc = pick_val();
    t.end_pos = pick_val();
    t.end_vel = pick_val();
    t.end_acc = pick_val();
    t.duration = pick_dur();
    return t;
  endfunction

  // response side: random stalls, one long hold-off, a quiet stretch
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 0;
    end else begin
      rsp.ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      traj_coef_t got;
      got.coef[0] = rsp.coef0;
      got.coef[1] = rsp.coef1;
      got.coef[2] = rsp.coef2;
      got.coef[3] = rsp.coef3;
      got.coef[4] = rsp.coef4;
      got.coef[5] = rsp.coef5;
      got.zero_duration = rsp.zero_duration;
      got.clipped = rsp.clipped;
      board.check_result(got);
    end
  end

  initial begin
    traj_req_t t;
    logic [31:0] corner [4];
    req.valid = 0;
    req.start_pos = 0;
    req.start_vel = 0;
    req.start_acc = 0;
    req.end_pos = 0;
    req.end_vel = 0;
    req.end_acc = 0;
    req.duration = 0;
    corner = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: zero duration, extremes of every field, ties in coef2
    for (int i = 0; i < 20; i++) begin
      t.start_pos = corner[i % 4];
      t.start_vel = corner[(i + 1) % 4];
      t.start_acc = (i < 4) ? (32'sd3 - 32'(i * 2)) : corner[(i + 2) % 4];
      t.end_pos = corner[(i + 3) % 4];
      t.end_vel = corner[(i / 4) % 4];
      t.end_acc = corner[(i / 2) % 4];
      case (i % 5)
        0: t.duration = 0;
        1: t.duration = 24'hFFFFFF;
        2: t.duration = 1;
        3: t.duration = 24'h10000;
        default: t.duration = 24'h800000;
      endcase
      send_request(t);
    end
    for (int n = 0; n < 1850; n++) begin
      if (n == 300) calm = 1;
      if (n == 500) calm = 0;
      if (n == 700) begin
        req.valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if (n == 900) hold_cycles = 200;
      send_request(random_request());
    end
    req.valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
